>>> rtl/pdd_pkg.sv
// pdd_pkg: types, widths, constants and helpers for the PID differential drive.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package pdd_pkg;

    // Field widths fixed by the interface
    localparam int ERROR_BITS     = 12;
    localparam int GAIN_FRAC_BITS = 10;
    localparam int GAIN_W         = 16;
    localparam int DT_W           = 16;
    localparam int SPD_W          = 8;
    localparam int INT_W          = 18;   // holds +/-100000

    // Arithmetic constants
    localparam int INTEGRAL_LIMIT = 100000;
    localparam int DEFAULT_DT_MS  = 10;
    localparam int MS_PER_S       = 1000;

    // Datapath widths
    localparam int E_W      = ERROR_BITS;
    localparam int DELTA_W  = E_W + 1;
    localparam int DNUM_W   = DELTA_W + 10;           // delta * 1000
    localparam int EDT_W    = E_W + DT_W + 1;         // e * dt
    localparam int INTS_W   = EDT_W + 1;              // integral + e * dt
    localparam int KIP_W    = GAIN_W + 1 + INT_W;     // ki * integral
    localparam int PE_W     = GAIN_W + 1 + E_W;       // kp * e
    localparam int DER_W    = DNUM_W;                 // derivative quotient
    localparam int KDP_W    = GAIN_W + 1 + DER_W;     // kd * derivative
    localparam int ITERM_W  = 24;                     // ki * integral / 1000
    localparam int CORR_W   = KDP_W + 2;
    localparam int LR_W     = CORR_W + 1;
    localparam int DIV_W    = 33;                     // |ki * integral| < 2^33
    localparam int DIVR_W   = DT_W;
    localparam int DIVC_W   = $clog2(DIV_W);
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Register reset values
    localparam logic [GAIN_W-1:0] KP_RESET   = 16'd2048;
    localparam logic [GAIN_W-1:0] KI_RESET   = 16'd51;
    localparam logic [GAIN_W-1:0] KD_RESET   = 16'd1024;
    localparam logic [SPD_W-1:0]  BASE_RESET = 8'd80;
    localparam logic [SPD_W-1:0]  MIN_RESET  = 8'd40;
    localparam logic [SPD_W-1:0]  MAX_RESET  = 8'd200;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_BASE = 3'd3,
        REG_MIN  = 3'd4,
        REG_MAX  = 3'd5
    } t_reg_idx;

    typedef enum logic [0:0] {
        CMD_UPDATE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_in_cmd;

    typedef struct packed {
        logic                  cmd;
        logic signed [E_W-1:0] position_error;
        logic [DT_W-1:0]       elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [SPD_W-1:0] left_speed;
        logic [SPD_W-1:0] right_speed;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [SPD_W-1:0]  base_speed;
        logic [SPD_W-1:0]  min_speed;
        logic [SPD_W-1:0]  max_speed;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load_in;
        logic mul;
        logic integ;
        logic div_start;
        logic div_iterm;    // divider operands: ki product / 1000, else delta * 1000 / dt
        logic kip_load;
        logic deriv_load;
        logic kdp_load;
        logic iterm_load;
        logic sum;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INTEG,
        S_DIV_D,
        S_START_I,
        S_DIV_I,
        S_SUM,
        S_OUT
    } t_state;

    // Lower bound is tested first; with crossed bounds it wins only below itself
    function automatic logic [SPD_W-1:0] limit_speed(
        input logic signed [LR_W-1:0] v,
        input logic [SPD_W-1:0]       lo,
        input logic [SPD_W-1:0]       hi
    );
        logic signed [LR_W-1:0] lo_s;
        logic signed [LR_W-1:0] hi_s;
        logic [SPD_W-1:0]       res;
        lo_s = $signed(LR_W'(lo));
        hi_s = $signed(LR_W'(hi));
        if (v < lo_s) begin
            res = lo;
        end else if (v > hi_s) begin
            res = hi;
        end else begin
            res = v[SPD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pdd_regs.sv
// pdd_regs: APB-style register file holding gains and speed limits.
// Depends on pdd_pkg for the register map and the configuration struct.
`default_nettype none

module pdd_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pdd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pdd_pkg::APB_DW-1:0]  pwdata,
    output logic [pdd_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    output pdd_pkg::t_cfg                    o_cfg
);

    pdd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[pdd_pkg::APB_AW-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes, access phase only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain    <= pdd_pkg::KP_RESET;
            r_cfg.ki_gain    <= pdd_pkg::KI_RESET;
            r_cfg.kd_gain    <= pdd_pkg::KD_RESET;
            r_cfg.base_speed <= pdd_pkg::BASE_RESET;
            r_cfg.min_speed  <= pdd_pkg::MIN_RESET;
            r_cfg.max_speed  <= pdd_pkg::MAX_RESET;
        end else if (wr_en) begin
            unique case (idx)
                pdd_pkg::REG_KP:   r_cfg.kp_gain    <= pwdata[pdd_pkg::GAIN_W-1:0];
                pdd_pkg::REG_KI:   r_cfg.ki_gain    <= pwdata[pdd_pkg::GAIN_W-1:0];
                pdd_pkg::REG_KD:   r_cfg.kd_gain    <= pwdata[pdd_pkg::GAIN_W-1:0];
                pdd_pkg::REG_BASE: r_cfg.base_speed <= pwdata[pdd_pkg::SPD_W-1:0];
                pdd_pkg::REG_MIN:  r_cfg.min_speed  <= pwdata[pdd_pkg::SPD_W-1:0];
                pdd_pkg::REG_MAX:  r_cfg.max_speed  <= pwdata[pdd_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (idx)
            pdd_pkg::REG_KP:   prdata = pdd_pkg::APB_DW'(r_cfg.kp_gain);
            pdd_pkg::REG_KI:   prdata = pdd_pkg::APB_DW'(r_cfg.ki_gain);
            pdd_pkg::REG_KD:   prdata = pdd_pkg::APB_DW'(r_cfg.kd_gain);
            pdd_pkg::REG_BASE: prdata = pdd_pkg::APB_DW'(r_cfg.base_speed);
            pdd_pkg::REG_MIN:  prdata = pdd_pkg::APB_DW'(r_cfg.min_speed);
            pdd_pkg::REG_MAX:  prdata = pdd_pkg::APB_DW'(r_cfg.max_speed);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/pdd_div.sv
// pdd_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on pdd_pkg for operand widths.
`default_nettype none

module pdd_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pdd_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [pdd_pkg::DIVR_W-1:0]   i_divisor,
    output logic [pdd_pkg::DIV_W-1:0]         o_quotient,
    output logic                              o_done
);

    logic                         r_busy;
    logic                         r_done;
    logic [pdd_pkg::DIVC_W-1:0]   r_cnt;
    logic [pdd_pkg::DIV_W-1:0]    r_quo;
    logic [pdd_pkg::DIVR_W-1:0]   r_rem;
    logic [pdd_pkg::DIVR_W-1:0]   r_dvs;
    logic [pdd_pkg::DIVR_W:0]     trial;
    logic [pdd_pkg::DIVR_W:0]     diff;
    logic                         fits;

    // Trial subtraction of the divisor from the shifted remainder
    assign trial = {r_rem, r_quo[pdd_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pdd_pkg::DIVC_W'(pdd_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pdd_pkg::DIV_W-2:0], fits};
            r_rem <= fits ? diff[pdd_pkg::DIVR_W-1:0] : trial[pdd_pkg::DIVR_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pdd_ctrl.sv
// pdd_ctrl: sequencing state machine and output valid flag.
// Depends on pdd_pkg for the state, command and status types.
`default_nettype none

module pdd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_cmd,
    input  wire logic              i_out_stall,
    input  pdd_pkg::t_status       i_status,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output pdd_pkg::t_cmd          o_cmd
);

    pdd_pkg::t_state r_state;
    pdd_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;
    logic            slot_free;

    assign accept      = i_in_valid && (r_state == pdd_pkg::S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != pdd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdd_pkg::S_IDLE: begin
                if (accept && (i_in_cmd == pdd_pkg::CMD_UPDATE)) begin
                    n_state = pdd_pkg::S_MUL;
                end
            end
            pdd_pkg::S_MUL:     n_state = pdd_pkg::S_INTEG;
            pdd_pkg::S_INTEG:   n_state = pdd_pkg::S_DIV_D;
            pdd_pkg::S_DIV_D: begin
                if (i_status.div_done) begin
                    n_state = pdd_pkg::S_START_I;
                end
            end
            pdd_pkg::S_START_I: n_state = pdd_pkg::S_DIV_I;
            pdd_pkg::S_DIV_I: begin
                if (i_status.div_done) begin
                    n_state = pdd_pkg::S_SUM;
                end
            end
            pdd_pkg::S_SUM:     n_state = pdd_pkg::S_OUT;
            pdd_pkg::S_OUT: begin
                if (slot_free) begin
                    n_state = pdd_pkg::S_IDLE;
                end
            end
            default:            n_state = pdd_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pdd_pkg::S_IDLE: begin
                o_cmd.clear   = accept && (i_in_cmd == pdd_pkg::CMD_CLEAR);
                o_cmd.load_in = accept && (i_in_cmd == pdd_pkg::CMD_UPDATE);
            end
            pdd_pkg::S_MUL:   o_cmd.mul = 1'b1;
            pdd_pkg::S_INTEG: begin
                o_cmd.integ     = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            pdd_pkg::S_DIV_D: begin
                o_cmd.kip_load   = 1'b1;
                o_cmd.deriv_load = i_status.div_done;
            end
            pdd_pkg::S_START_I: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_iterm = 1'b1;
                o_cmd.kdp_load  = 1'b1;
            end
            pdd_pkg::S_DIV_I: begin
                o_cmd.div_iterm  = 1'b1;
                o_cmd.iterm_load = i_status.div_done;
            end
            pdd_pkg::S_SUM:   o_cmd.sum = 1'b1;
            pdd_pkg::S_OUT:   o_cmd.out_load = slot_free;
            default: ;
        endcase
    end

    // Output register valid: set on load, cleared by a transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pdd_dp.sv
// pdd_dp: PID datapath - state, products, shared divider, output register.
// Depends on pdd_pkg and instantiates pdd_div.
`default_nettype none

module pdd_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  pdd_pkg::t_in            i_in_data,
    input  pdd_pkg::t_cfg           i_cfg,
    input  pdd_pkg::t_cmd           i_cmd,
    output pdd_pkg::t_status        o_status,
    output pdd_pkg::t_out           o_out_data
);

    // Controller state kept across items
    logic signed [pdd_pkg::INT_W-1:0]   r_integ;
    logic signed [pdd_pkg::E_W-1:0]     r_prev;

    // Per-item working registers
    logic signed [pdd_pkg::E_W-1:0]     r_e;
    logic [pdd_pkg::DT_W-1:0]           r_dt;
    logic signed [pdd_pkg::EDT_W-1:0]   r_edt;
    logic signed [pdd_pkg::PE_W-1:0]    r_pe;
    logic signed [pdd_pkg::DNUM_W-1:0]  r_dnum;
    logic signed [pdd_pkg::KIP_W-1:0]   r_kip;
    logic signed [pdd_pkg::DER_W-1:0]   r_deriv;
    logic signed [pdd_pkg::KDP_W-1:0]   r_kdp;
    logic signed [pdd_pkg::ITERM_W-1:0] r_iterm;
    logic signed [pdd_pkg::CORR_W-1:0]  r_corr;
    pdd_pkg::t_out                      r_out;

    logic signed [pdd_pkg::GAIN_W:0]    kp_s;
    logic signed [pdd_pkg::GAIN_W:0]    ki_s;
    logic signed [pdd_pkg::GAIN_W:0]    kd_s;
    logic signed [pdd_pkg::DT_W:0]      dt_s;
    logic signed [pdd_pkg::DELTA_W-1:0] delta;
    logic signed [pdd_pkg::EDT_W-1:0]   edt_w;
    logic signed [pdd_pkg::PE_W-1:0]    pe_w;
    logic signed [pdd_pkg::DNUM_W-1:0]  dnum_w;
    logic signed [pdd_pkg::KIP_W-1:0]   kip_w;
    logic signed [pdd_pkg::KDP_W-1:0]   kdp_w;
    logic signed [pdd_pkg::INTS_W-1:0]  integ_sum;
    logic signed [pdd_pkg::INT_W-1:0]   integ_lim;
    logic [pdd_pkg::DNUM_W-1:0]         dnum_mag;
    logic [pdd_pkg::KIP_W-1:0]          kip_mag;
    logic [pdd_pkg::DIV_W-1:0]          div_dvd;
    logic [pdd_pkg::DIVR_W-1:0]         div_dvs;
    logic [pdd_pkg::DIV_W-1:0]          div_q;
    logic                               div_done;
    logic signed [pdd_pkg::DER_W-1:0]   deriv_q;
    logic signed [pdd_pkg::ITERM_W-1:0] iterm_q;
    logic signed [pdd_pkg::CORR_W-1:0]  corr_w;
    logic signed [pdd_pkg::LR_W-1:0]    base_q;
    logic signed [pdd_pkg::LR_W-1:0]    left_q;
    logic signed [pdd_pkg::LR_W-1:0]    right_q;
    logic signed [pdd_pkg::LR_W-1:0]    left_i;
    logic signed [pdd_pkg::LR_W-1:0]    right_i;

    // Gains and elapsed time as non-negative signed operands
    assign kp_s = $signed({1'b0, i_cfg.kp_gain});
    assign ki_s = $signed({1'b0, i_cfg.ki_gain});
    assign kd_s = $signed({1'b0, i_cfg.kd_gain});
    assign dt_s = $signed({1'b0, r_dt});

    // First products: e*dt, kp*e, (e - prev)*1000
    assign delta  = pdd_pkg::DELTA_W'(r_e) - pdd_pkg::DELTA_W'(r_prev);
    assign edt_w  = pdd_pkg::EDT_W'(r_e) * pdd_pkg::EDT_W'(dt_s);
    assign pe_w   = pdd_pkg::PE_W'(kp_s) * pdd_pkg::PE_W'(r_e);
    assign dnum_w = pdd_pkg::DNUM_W'(delta) * pdd_pkg::DNUM_W'(pdd_pkg::MS_PER_S);

    // Integral update with anti-windup clamp
    assign integ_sum = pdd_pkg::INTS_W'(r_integ) + pdd_pkg::INTS_W'(r_edt);
    always_comb begin
        if (integ_sum > pdd_pkg::INTS_W'(pdd_pkg::INTEGRAL_LIMIT)) begin
            integ_lim = pdd_pkg::INT_W'(pdd_pkg::INTEGRAL_LIMIT);
        end else if (integ_sum < -pdd_pkg::INTS_W'(pdd_pkg::INTEGRAL_LIMIT)) begin
            integ_lim = -pdd_pkg::INT_W'(pdd_pkg::INTEGRAL_LIMIT);
        end else begin
            integ_lim = integ_sum[pdd_pkg::INT_W-1:0];
        end
    end

    // Later products
    assign kip_w = pdd_pkg::KIP_W'(ki_s) * pdd_pkg::KIP_W'(r_integ);
    assign kdp_w = pdd_pkg::KDP_W'(kd_s) * pdd_pkg::KDP_W'(r_deriv);

    // Divider operands: magnitudes, sign restored on the quotient
    assign dnum_mag = pdd_pkg::DNUM_W'(r_dnum[pdd_pkg::DNUM_W-1] ? -r_dnum : r_dnum);
    assign kip_mag  = pdd_pkg::KIP_W'(r_kip[pdd_pkg::KIP_W-1] ? -r_kip : r_kip);
    assign div_dvd  = i_cmd.div_iterm ? kip_mag[pdd_pkg::DIV_W-1:0]
                                      : pdd_pkg::DIV_W'(dnum_mag);
    assign div_dvs  = i_cmd.div_iterm ? pdd_pkg::DIVR_W'(pdd_pkg::MS_PER_S) : r_dt;

    pdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    assign o_status.div_done = div_done;

    // Truncation toward zero: negate the magnitude quotient
    assign deriv_q = $signed(div_q[pdd_pkg::DER_W-1:0]);
    assign iterm_q = $signed(div_q[pdd_pkg::ITERM_W-1:0]);

    // Correction sum and speed outputs
    assign corr_w  = pdd_pkg::CORR_W'(r_pe) + pdd_pkg::CORR_W'(r_iterm)
                   + pdd_pkg::CORR_W'(r_kdp);
    assign base_q  = $signed(pdd_pkg::LR_W'({i_cfg.base_speed,
                                              {pdd_pkg::GAIN_FRAC_BITS{1'b0}}}));
    assign left_q  = base_q - pdd_pkg::LR_W'(r_corr);
    assign right_q = base_q + pdd_pkg::LR_W'(r_corr);
    assign left_i  = left_q >>> pdd_pkg::GAIN_FRAC_BITS;
    assign right_i = right_q >>> pdd_pkg::GAIN_FRAC_BITS;

    // Stored state: integral and last error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_cmd.clear) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.mul) begin
                r_prev <= r_e;
            end
            if (i_cmd.integ) begin
                r_integ <= integ_lim;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_e  <= i_in_data.position_error;
            r_dt <= (i_in_data.elapsed_ms == '0) ? pdd_pkg::DT_W'(pdd_pkg::DEFAULT_DT_MS)
                                                 : i_in_data.elapsed_ms;
        end
        if (i_cmd.mul) begin
            r_edt  <= edt_w;
            r_pe   <= pe_w;
            r_dnum <= dnum_w;
        end
        if (i_cmd.kip_load) begin
            r_kip <= kip_w;
        end
        if (i_cmd.deriv_load) begin
            r_deriv <= r_dnum[pdd_pkg::DNUM_W-1] ? -deriv_q : deriv_q;
        end
        if (i_cmd.kdp_load) begin
            r_kdp <= kdp_w;
        end
        if (i_cmd.iterm_load) begin
            r_iterm <= r_kip[pdd_pkg::KIP_W-1] ? -iterm_q : iterm_q;
        end
        if (i_cmd.sum) begin
            r_corr <= corr_w;
        end
        if (i_cmd.out_load) begin
            r_out.left_speed  <= pdd_pkg::limit_speed(left_i, i_cfg.min_speed,
                                                      i_cfg.max_speed);
            r_out.right_speed <= pdd_pkg::limit_speed(right_i, i_cfg.min_speed,
                                                      i_cfg.max_speed);
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> rtl/pid_differential_drive.sv
// pid_differential_drive: top level of the PID line-follower speed controller.
// Depends on pdd_pkg; instantiates pdd_regs, pdd_ctrl and pdd_dp.
//
//   port group       direction  handshake              payload
//   update in        input      i_in_valid/o_in_stall  i_in_data (t_in)
//   speeds out       output     o_out_valid/i_out_stall o_out_data (t_out)
//   register access  input      psel/penable/pready    paddr, pwdata, prdata
//
// An update makes two 33-step passes through the one radix-2 divider
// (derivative, then integral term).
// A clear transfer gives no result.
// Reset (synchronous) zeroes integral and last error and loads default gains.
// A finished result waits in the output register while the next update is taken;
// only a new result meeting a stalled full output register holds the sequencer.
`default_nettype none

module pid_differential_drive (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  pdd_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output pdd_pkg::t_out                    o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pdd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pdd_pkg::APB_DW-1:0]  pwdata,
    output logic [pdd_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    pdd_pkg::t_cfg    cfg;
    pdd_pkg::t_cmd    cmd;
    pdd_pkg::t_status status;

    pdd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pdd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/pid_differential_drive_test.sv
// pid_differential_drive_test: self-checking testbench for the PID differential drive.
// Depends on pdd_pkg and pid_differential_drive; holds its own speed predictor
// and drives the update, speed and register ports.
`timescale 1ns / 100ps

// Predicts left/right duty from each accepted update and checks arriving speeds
class speed_predictor;
    pdd_pkg::t_cfg cfg;
    longint        integral_acc;
    longint        last_error;
    pdd_pkg::t_out expected_speeds[$];
    int            mismatches;

    function new();
        cfg.kp_gain    = pdd_pkg::KP_RESET;
        cfg.ki_gain    = pdd_pkg::KI_RESET;
        cfg.kd_gain    = pdd_pkg::KD_RESET;
        cfg.base_speed = pdd_pkg::BASE_RESET;
        cfg.min_speed  = pdd_pkg::MIN_RESET;
        cfg.max_speed  = pdd_pkg::MAX_RESET;
        integral_acc   = 0;
        last_error     = 0;
        mismatches     = 0;
    endfunction

    // Register write as the block sees it; unmapped indexes fall through
    function void write_reg(int idx, logic [31:0] word);
        case (idx)
            pdd_pkg::REG_KP:   cfg.kp_gain    = word[15:0];
            pdd_pkg::REG_KI:   cfg.ki_gain    = word[15:0];
            pdd_pkg::REG_KD:   cfg.kd_gain    = word[15:0];
            pdd_pkg::REG_BASE: cfg.base_speed = word[7:0];
            pdd_pkg::REG_MIN:  cfg.min_speed  = word[7:0];
            pdd_pkg::REG_MAX:  cfg.max_speed  = word[7:0];
            default: ;
        endcase
    endfunction

    // Lower bound is tested first; when min exceeds max it wins only below min
    function logic [7:0] bound_speed(longint v);
        longint lo;
        longint hi;
        lo = cfg.min_speed;
        hi = cfg.max_speed;
        if (v < lo) return cfg.min_speed;
        if (v > hi) return cfg.max_speed;
        return 8'(v);
    endfunction

    function void note_update(pdd_pkg::t_in item);
        longint e, dt, integ, deriv, iterm, corr, base_q;
        longint kp, ki, kd;
        pdd_pkg::t_out want;
        if (item.cmd == pdd_pkg::CMD_CLEAR) begin
            integral_acc = 0;
            last_error   = 0;
            return;
        end
        e  = longint'($signed(item.position_error));
        dt = item.elapsed_ms;
        if (dt == 0) dt = pdd_pkg::DEFAULT_DT_MS;
        // integral in error*ms, saturating
        integ = integral_acc + e * dt;
        if (integ > pdd_pkg::INTEGRAL_LIMIT) integ = pdd_pkg::INTEGRAL_LIMIT;
        if (integ < -pdd_pkg::INTEGRAL_LIMIT) integ = -pdd_pkg::INTEGRAL_LIMIT;
        integral_acc = integ;
        // both divisions truncate toward zero
        deriv      = ((e - last_error) * pdd_pkg::MS_PER_S) / dt;
        last_error = e;
        kp = cfg.kp_gain;
        ki = cfg.ki_gain;
        kd = cfg.kd_gain;
        iterm  = (ki * integ) / pdd_pkg::MS_PER_S;
        corr   = kp * e + iterm + kd * deriv;
        base_q = longint'(cfg.base_speed) << pdd_pkg::GAIN_FRAC_BITS;
        want.left_speed  = bound_speed((base_q - corr) >>> pdd_pkg::GAIN_FRAC_BITS);
        want.right_speed = bound_speed((base_q + corr) >>> pdd_pkg::GAIN_FRAC_BITS);
        expected_speeds.push_back(want);
    endfunction

    function void check_speeds(pdd_pkg::t_out got);
        pdd_pkg::t_out want;
        if (expected_speeds.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected speeds left=%0d right=%0d",
                         got.left_speed, got.right_speed);
            mismatches++;
            return;
        end
        want = expected_speeds.pop_front();
        if (got.left_speed !== want.left_speed) begin
            if (mismatches < 10)
                $display("left_speed mismatch: expected %0d, got %0d",
                         want.left_speed, got.left_speed);
            mismatches++;
        end
        if (got.right_speed !== want.right_speed) begin
            if (mismatches < 10)
                $display("right_speed mismatch: expected %0d, got %0d",
                         want.right_speed, got.right_speed);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_speeds.size();
    endfunction
endclass

module pid_differential_drive_test;
    import pdd_pkg::*;

    localparam int SPARE_REG_A   = 6;     // beyond the register map
    localparam int SPARE_REG_B   = 7;
    localparam int SETTLE_CYCLES = 150;   // covers one update plus a clear
    localparam int HOLD_CYCLES   = 900;
    localparam int RUN_LIMIT     = 500000;
    localparam int NUM_PHASES    = 9;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                feed_valid;
    logic                o_in_stall;
    t_in                 feed_data;
    logic                o_out_valid;
    logic                speeds_stall;
    t_out                o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    speed_predictor      sb;
    int                  cycle_count = 0;
    bit                  feed_idle;
    bit                  sink_idle;
    bit                  hold_request;

    pid_differential_drive dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (feed_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (feed_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (speeds_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[pid_differential_drive] ERROR");
            $finish;
        end
    end

    // Speed transfers are checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !speeds_stall) sb.check_speeds(o_out_data);
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : speed_sink
        int span;
        speeds_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                speeds_stall <= 1'b1;
                span = 0;
                while (span < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    span++;
                end
                speeds_stall <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                speeds_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                speeds_stall <= 1'b0;
            end
        end
    end

    function automatic t_in pack_item(t_in_cmd c, int err, int ms);
        t_in item;
        item.cmd            = c;
        item.position_error = E_W'(err);
        item.elapsed_ms     = DT_W'(ms);
        return item;
    endfunction

    // Offer one update and hold it until the transfer, then maybe pause
    task automatic send_item(t_in item);
        feed_valid <= 1'b1;
        feed_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_update(item);
        if (feed_idle && $urandom_range(0, 4) == 0) begin
            feed_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_reg(int idx, logic [15:0] value);
        logic [31:0] word;
        word = {16'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, word);
    endtask

    // Wait for every predicted result, then let a trailing clear finish
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : main_flow
        int   phase_len [NUM_PHASES];
        t_in  directed_q[$];
        t_cfg next_cfg;
        t_in  upd;
        sb = new();
        phase_len = '{60, 40, 30, 40, 80, 80, 60, 80, 80};
        i_rst_n    <= 1'b0;
        feed_valid <= 1'b0;
        feed_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        feed_idle    = 1'b1;
        sink_idle    = 1'b1;
        hold_request = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero elapsed time, error and time extremes, clears
        directed_q.push_back(pack_item(CMD_UPDATE, 0, 0));
        directed_q.push_back(pack_item(CMD_UPDATE, 2047, 1));
        directed_q.push_back(pack_item(CMD_UPDATE, -2048, 1));
        directed_q.push_back(pack_item(CMD_UPDATE, -2048, 65535));
        directed_q.push_back(pack_item(CMD_UPDATE, 2047, 65535));
        directed_q.push_back(pack_item(CMD_CLEAR, 2047, 65535));
        directed_q.push_back(pack_item(CMD_UPDATE, 10, 10));
        directed_q.push_back(pack_item(CMD_UPDATE, -10, 0));
        directed_q.push_back(pack_item(CMD_UPDATE, 5, 20));
        directed_q.push_back(pack_item(CMD_CLEAR, -1, 0));
        directed_q.push_back(pack_item(CMD_CLEAR, -2048, 1));
        directed_q.push_back(pack_item(CMD_UPDATE, 0, 65535));
        directed_q.push_back(pack_item(CMD_UPDATE, 1, 1));
        directed_q.push_back(pack_item(CMD_UPDATE, -1, 3));
        directed_q.push_back(pack_item(CMD_UPDATE, 300, 7));
        directed_q.push_back(pack_item(CMD_UPDATE, -300, 32768));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // New settings, written only once the block is idle
            if (ph > 0) begin
                drain();
                next_cfg = sb.cfg;
                case (ph)
                    1: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'd255};
                    2: next_cfg = '{16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd255};
                    3: next_cfg = '{16'd512, 16'd100, 16'd16, 8'd128, 8'd150, 8'd100};
                    4: next_cfg = '{16'd64, 16'd200, 16'd2, 8'd128, 8'd0, 8'd255};
                    5: begin
                        next_cfg.kp_gain    = 16'($urandom_range(0, 1023));
                        next_cfg.ki_gain    = 16'($urandom_range(0, 4095));
                        next_cfg.kd_gain    = 16'($urandom_range(0, 63));
                        next_cfg.base_speed = 8'($urandom);
                        next_cfg.min_speed  = 8'($urandom_range(0, 60));
                        next_cfg.max_speed  = 8'($urandom_range(180, 255));
                    end
                    6: next_cfg = t_cfg'({$urandom, $urandom, 16'($urandom)});
                    7: next_cfg = '{KP_RESET, KI_RESET, KD_RESET,
                                   BASE_RESET, MIN_RESET, MAX_RESET};
                    default: begin
                        next_cfg.kp_gain    = 16'($urandom_range(0, 300));
                        next_cfg.ki_gain    = 16'($urandom_range(0, 1000));
                        next_cfg.kd_gain    = 16'($urandom_range(0, 8));
                        next_cfg.base_speed = 8'($urandom_range(100, 150));
                        next_cfg.min_speed  = 8'($urandom_range(0, 30));
                        next_cfg.max_speed  = 8'($urandom_range(220, 255));
                    end
                endcase
                write_reg(REG_KP, next_cfg.kp_gain);
                write_reg(REG_KI, next_cfg.ki_gain);
                write_reg(REG_KD, next_cfg.kd_gain);
                write_reg(REG_BASE, 16'(next_cfg.base_speed));
                write_reg(REG_MIN, 16'(next_cfg.min_speed));
                write_reg(REG_MAX, 16'(next_cfg.max_speed));
                // writes past the map must leave the settings alone
                if (ph == 7) begin
                    write_reg(SPARE_REG_A, 16'($urandom));
                    write_reg(SPARE_REG_B, 16'($urandom));
                end
            end

            // no idling in the zero-gain phase and in the last part
            feed_idle = (ph != 2 && ph != NUM_PHASES - 1);
            sink_idle = feed_idle;

            if (ph == 0) begin
                foreach (directed_q[i]) send_item(directed_q[i]);
            end

            for (int k = 0; k < phase_len[ph]; k++) begin
                if (ph == 5 && k == 10) hold_request = 1'b1;
                upd.cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_UPDATE;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                        upd.position_error = E_W'(int'($urandom_range(0, 127)) - 64);
                    10, 11:
                        upd.position_error = E_W'(int'($urandom_range(0, 1023)) - 512);
                    12, 13, 14:
                        case ($urandom_range(0, 3))
                            0: upd.position_error = E_W'(-2048);
                            1: upd.position_error = E_W'(2047);
                            2: upd.position_error = '0;
                            default: upd.position_error = '1;
                        endcase
                    default: upd.position_error = E_W'($urandom);
                endcase
                case ($urandom_range(0, 19))
                    0, 1:
                        upd.elapsed_ms = '0;
                    2, 3, 4:
                        upd.elapsed_ms = DT_W'($urandom_range(51, 1000));
                    5, 6, 7:
                        upd.elapsed_ms = DT_W'($urandom);
                    default:
                        upd.elapsed_ms = DT_W'($urandom_range(1, 50));
                endcase
                send_item(upd);
            end
            feed_valid <= 1'b0;
        end

        // End of run: all results in, then a final settle
        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[pid_differential_drive] OK");
        end else begin
            $display("[pid_differential_drive] ERROR");
        end
        $finish;
    end
endmodule
